[hw/rtl/sa_pkg.sv]
// Shared widths, codes, pipeline record types and the exp2 root table
// for the spotlight attenuation block. Depends on nothing.
package sa_pkg;

	localparam int FRAC_BITS = 16;
	localparam int Q_FRAC = 16;
	localparam int AW = 32;
	localparam int RW = 18;
	localparam int EW = 16;
	localparam int THW = 18;
	localparam int OW = 17;
	localparam int CFG_IW = 3;
	localparam int NW = 51;
	localparam int DOTW = NW + 1;
	localparam int PRW = RW + AW;
	localparam int LENW = 32;
	localparam int CW = 21;
	localparam int PBW = 5;
	localparam int MW = 31;
	localparam int LIW = 6;
	localparam int LW = FRAC_BITS + LIW;
	localparam int EXP_FRAC = 8;
	localparam int PW = LW + EW + 1;
	localparam int YW = PW - EXP_FRAC;
	localparam int QW = YW - FRAC_BITS;
	localparam int SHW = 5;
	localparam int EXP_SH0 = MW - 1 - Q_FRAC;
	localparam int Q_MIN = EXP_SH0 - MW + 1;
	localparam int DENW = 18;
	localparam int TW = 17;
	localparam int TRW = DENW + TW - 1;
	localparam int CSW = CW + 1;
	localparam int TTW = 2 * TW - 1;
	localparam int SWW = 18;
	localparam int SPW = SWW + TTW;
	localparam int ONE_Q16 = 1 << Q_FRAC;
	localparam int SMOOTH_K = 3 << Q_FRAC;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW = 2;
	localparam int FIFO_CW = 3;
	localparam int SQ_CNTW = 2;
	localparam int RT_CNTW = 5;

	typedef enum logic [CFG_IW-1:0] {
		REG_AXIS_X       = 3'd0,
		REG_AXIS_Y       = 3'd1,
		REG_AXIS_Z       = 3'd2,
		REG_EXPONENT     = 3'd3,
		REG_CONE_RADIUS  = 3'd4,
		REG_CONE_FALLOFF = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_SHIFT,
		ST_SQ,
		ST_SQRT,
		ST_IDLE
	} setup_state_t;

	typedef enum logic [1:0] {
		SM_OFF,
		SM_ZERO,
		SM_ONE,
		SM_CALC
	} sm_mode_t;

	typedef struct packed {
		logic                  zero;
		logic signed [AW-1:0]  ax;
		logic signed [AW-1:0]  ay;
		logic signed [AW-1:0]  az;
		logic [LENW-1:0]       len;
	} axis_info_t;

	typedef struct packed {
		logic          kill;
		logic [NW-1:0] n;
	} fe_item_t;

	typedef struct packed {
		logic          kill;
		logic [NW-1:0] rem;
		logic [CW-1:0] quo;
	} div_t;

	typedef struct packed {
		logic                 kill;
		logic                 czero;
		logic [CW-1:0]        c;
		logic [PBW-1:0]       p;
		logic [MW-1:0]        m;
		logic [FRAC_BITS-1:0] frac;
	} lg_t;

	typedef struct packed {
		logic                 kill;
		logic                 czero;
		logic [CW-1:0]        c;
		logic signed [PW-1:0] prod;
	} mu_t;

	typedef struct packed {
		logic                 kill;
		logic [CW-1:0]        c;
		logic                 fix;
		logic [OW-1:0]        fix_val;
		logic [FRAC_BITS-1:0] f;
		logic [SHW-1:0]       sh;
		logic [MW-1:0]        r;
	} ex_t;

	typedef struct packed {
		logic          kill;
		logic [CW-1:0] c;
		logic [OW-1:0] power;
	} pw_t;

	typedef struct packed {
		logic            kill;
		logic [OW-1:0]   power;
		sm_mode_t        mode;
		logic [TRW-1:0]  rem;
		logic [DENW-1:0] den;
		logic [TW-1:0]   t;
	} sd_t;

	typedef struct packed {
		logic           kill;
		logic [OW-1:0]  power;
		sm_mode_t       mode;
		logic [TTW-1:0] tt;
		logic [SWW-1:0] w;
	} tt_t;

	typedef struct packed {
		logic          kill;
		logic [OW-1:0] power;
		sm_mode_t      mode;
		logic [OW-1:0] s;
	} ss_t;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] b;
		x = v;
		res = '0;
		for (int j = 0; j < 32; j++) begin
			b = 64'd1 << (62 - 2 * j);
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
		end
		return res;
	endfunction

	typedef logic [MW-1:0] root_tab_t [FRAC_BITS];

	function automatic root_tab_t calc_roots();
		root_tab_t tab;
		logic [63:0] rt;
		rt = isqrt64(64'd1 << (2 * MW - 1));
		for (int k = 0; k < FRAC_BITS; k++) begin
			tab[k] = rt[MW-1:0];
			rt = isqrt64(rt << (MW - 1));
		end
		return tab;
	endfunction

	localparam root_tab_t ROOTS = calc_roots();

endpackage

[hw/rtl/spotlight_attenuation.sv]
// Spotlight attenuation top level: configuration registers, front end,
// queue and back end. Uses sa_pkg, sa_setup, sa_front, sa_fifo, sa_back.
// The path from the accepting edge to done runs through the one-bit-per-stage
// dividers and the log2 and exp2 stage chains.
// Throughput is one ray per cycle while busy is low; the receiver cannot stall results.
// After reset, and after each axis write, busy stays high
// while the axis is scaled and its length is found bit by bit.
module spotlight_attenuation (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [17:0]   ray_x,
	input  logic signed [17:0]   ray_y,
	input  logic signed [17:0]   ray_z,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 done,
	output logic [16:0]          attenuation
);
	import sa_pkg::*;

	logic signed [AW-1:0] axis_x_q, axis_y_q, axis_z_q;
	logic [EW-1:0] exponent_q;
	logic signed [THW-1:0] cone_radius_q, cone_falloff_q;
	logic axis_wr, setup_busy, accept, push, fifo_empty;
	axis_info_t info;
	fe_item_t fe_item, be_item;
	logic [FIFO_CW-1:0] fifo_count;

	assign axis_wr = cfg_we && (cfg_index == REG_AXIS_X || cfg_index == REG_AXIS_Y
		|| cfg_index == REG_AXIS_Z);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_x_q <= '0;
			axis_y_q <= '0;
			axis_z_q <= AW'(ONE_Q16);
			exponent_q <= EW'(1 << EXP_FRAC);
			cone_radius_q <= '0;
			cone_falloff_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_AXIS_X:       axis_x_q <= cfg_data;
				REG_AXIS_Y:       axis_y_q <= cfg_data;
				REG_AXIS_Z:       axis_z_q <= cfg_data;
				REG_EXPONENT:     exponent_q <= cfg_data[EW-1:0];
				REG_CONE_RADIUS:  cone_radius_q <= cfg_data[THW-1:0];
				REG_CONE_FALLOFF: cone_falloff_q <= cfg_data[THW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign busy = setup_busy || (fifo_count >= FIFO_CW'(FIFO_DEPTH - 2));
	assign accept = start && !busy;

	sa_setup u_setup (
		.clk     (clk),
		.arst_n  (arst_n),
		.restart (axis_wr),
		.axis_x  (axis_x_q),
		.axis_y  (axis_y_q),
		.axis_z  (axis_z_q),
		.busy    (setup_busy),
		.info    (info)
	);

	sa_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.ray_x  (ray_x),
		.ray_y  (ray_y),
		.ray_z  (ray_z),
		.info   (info),
		.push   (push),
		.item   (fe_item)
	);

	sa_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (fe_item),
		.pop    (!fifo_empty),
		.dout   (be_item),
		.empty  (fifo_empty),
		.count  (fifo_count)
	);

	sa_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_v         (!fifo_empty),
		.in_item      (be_item),
		.info         (info),
		.exponent     (exponent_q),
		.cone_radius  (cone_radius_q),
		.cone_falloff (cone_falloff_q),
		.done         (done),
		.attenuation  (attenuation)
	);

	a_fifo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_count <= FIFO_CW'(FIFO_DEPTH))
		else $error("queue count exceeds its depth");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (attenuation <= OW'(ONE_Q16)))
		else $error("attenuation beat above one");

	a_axis_setup: assert property (@(posedge clk) disable iff (!arst_n)
		axis_wr |=> busy)
		else $error("axis write did not start setup");

endmodule

[hw/rtl/sa_setup.sv]
// Axis setup sequencer: scales the spot axis and finds its length.
// Uses sa_pkg; one shift, one square or one root step per cycle.
module sa_setup (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     restart,
	input  logic signed [31:0]       axis_x,
	input  logic signed [31:0]       axis_y,
	input  logic signed [31:0]       axis_z,
	output logic                     busy,
	output sa_pkg::axis_info_t       info
);
	import sa_pkg::*;

	setup_state_t state_q, state_d;
	logic signed [AW-1:0] ax_q, ay_q, az_q, ax_d, ay_d, az_d;
	logic zero_q, zero_d;
	logic [SQ_CNTW-1:0] sq_cnt_q, sq_cnt_d;
	logic [RT_CNTW-1:0] rt_cnt_q, rt_cnt_d;
	logic [63:0] x_q, x_d, res_q, res_d;
	logic [AW-1:0] abs_x, abs_y, abs_z, sel;
	logic [63:0] sq, bitv, trial;
	logic big;

	always_comb begin
		abs_x = ax_q[AW-1] ? AW'(-ax_q) : AW'(ax_q);
		abs_y = ay_q[AW-1] ? AW'(-ay_q) : AW'(ay_q);
		abs_z = az_q[AW-1] ? AW'(-az_q) : AW'(az_q);
		big = (abs_x >= (AW'(1) << (AW - 2))) || (abs_y >= (AW'(1) << (AW - 2)))
			|| (abs_z >= (AW'(1) << (AW - 2)));
		case (sq_cnt_q)
			2'd0: sel = abs_x;
			2'd1: sel = abs_y;
			default: sel = abs_z;
		endcase
		sq = 64'(sel) * 64'(sel);
		bitv = 64'd1 << (6'd62 - {rt_cnt_q, 1'b0});
		trial = res_q + bitv;
	end

	always_comb begin
		state_d = state_q;
		ax_d = ax_q;
		ay_d = ay_q;
		az_d = az_q;
		zero_d = zero_q;
		sq_cnt_d = sq_cnt_q;
		rt_cnt_d = rt_cnt_q;
		x_d = x_q;
		res_d = res_q;
		unique case (state_q)
			ST_LOAD: begin
				ax_d = axis_x;
				ay_d = axis_y;
				az_d = axis_z;
				x_d = '0;
				sq_cnt_d = '0;
				if (axis_x == '0 && axis_y == '0 && axis_z == '0) begin
					zero_d = 1'b1;
					state_d = ST_IDLE;
				end else begin
					zero_d = 1'b0;
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (big) begin
					state_d = ST_SQ;
				end else begin
					ax_d = ax_q <<< 1;
					ay_d = ay_q <<< 1;
					az_d = az_q <<< 1;
				end
			end
			ST_SQ: begin
				x_d = x_q + sq;
				sq_cnt_d = sq_cnt_q + 1'b1;
				if (sq_cnt_q == 2'd2) begin
					res_d = '0;
					rt_cnt_d = '0;
					state_d = ST_SQRT;
				end
			end
			ST_SQRT: begin
				if (x_q >= trial) begin
					x_d = x_q - trial;
					res_d = (res_q >> 1) + bitv;
				end else begin
					res_d = res_q >> 1;
				end
				rt_cnt_d = rt_cnt_q + 1'b1;
				if (rt_cnt_q == '1) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
			end
			default: begin
				state_d = ST_LOAD;
			end
		endcase
		if (restart) begin
			state_d = ST_LOAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		ax_q <= ax_d;
		ay_q <= ay_d;
		az_q <= az_d;
		zero_q <= zero_d;
		sq_cnt_q <= sq_cnt_d;
		rt_cnt_q <= rt_cnt_d;
		x_q <= x_d;
		res_q <= res_d;
	end

	assign busy = (state_q != ST_IDLE);
	assign info = '{zero: zero_q, ax: ax_q, ay: ay_q, az: az_q, len: res_q[LENW-1:0]};

endmodule

[hw/rtl/sa_front.sv]
// Front end: takes ray beats, forms the negated dot product with the axis
// and marks rays whose negated dot product is not positive, or all rays when the axis is zero. Uses sa_pkg.
module sa_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic signed [17:0]    ray_x,
	input  logic signed [17:0]    ray_y,
	input  logic signed [17:0]    ray_z,
	input  sa_pkg::axis_info_t    info,
	output logic                  push,
	output sa_pkg::fe_item_t      item
);
	import sa_pkg::*;

	logic v_s1, v_s2;
	logic signed [PRW-1:0] px_s1, py_s1, pz_s1;
	fe_item_t item_s2;
	logic signed [DOTW-1:0] dot, n;

	always_comb begin
		dot = DOTW'(px_s1) + DOTW'(py_s1) + DOTW'(pz_s1);
		n = -dot;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		px_s1 <= PRW'(ray_x) * PRW'(info.ax);
		py_s1 <= PRW'(ray_y) * PRW'(info.ay);
		pz_s1 <= PRW'(ray_z) * PRW'(info.az);
		item_s2.kill <= info.zero || n[DOTW-1] || (n == '0);
		item_s2.n <= n[NW-1:0];
	end

	assign push = v_s2;
	assign item = item_s2;

endmodule

[hw/rtl/sa_fifo.sv]
// Short queue between the front end and the back end.
// Uses sa_pkg for the entry type and depth.
module sa_fifo (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  sa_pkg::fe_item_t              din,
	input  logic                          pop,
	output sa_pkg::fe_item_t              dout,
	output logic                          empty,
	output logic [sa_pkg::FIFO_CW-1:0]    count
);
	import sa_pkg::*;

	fe_item_t mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q, rd_q;
	logic [FIFO_CW-1:0] cnt_q;
	logic do_pop;

	assign do_pop = pop && (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(do_pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

	assign dout = mem_q[rd_q];
	assign empty = (cnt_q == '0);
	assign count = cnt_q;

endmodule

[hw/rtl/sa_back.sv]
// Back end: cosine divide, log2, exponent scale, exp2 and smoothstep,
// one step per pipeline stage. Uses sa_pkg.
module sa_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_v,
	input  sa_pkg::fe_item_t      in_item,
	input  sa_pkg::axis_info_t    info,
	input  logic [15:0]           exponent,
	input  logic signed [17:0]    cone_radius,
	input  logic signed [17:0]    cone_falloff,
	output logic                  done,
	output logic [16:0]           attenuation
);
	import sa_pkg::*;

	logic div_v_s [CW+1];
	div_t div_s [CW+1];
	div_t div_nx [CW];
	logic lg_v_s [FRAC_BITS+1];
	lg_t lg_s [FRAC_BITS+1];
	lg_t lg_nx [FRAC_BITS+1];
	logic mu_v_s;
	mu_t mu_s;
	logic ex_v_s [FRAC_BITS+1];
	ex_t ex_s [FRAC_BITS+1];
	ex_t ex_nx [FRAC_BITS+1];
	logic pw_v_s;
	pw_t pw_s;
	logic sd_v_s [TW+1];
	sd_t sd_s [TW+1];
	sd_t sd_nx [TW+1];
	logic tt_v_s;
	tt_t tt_s;
	logic ss_v_s;
	ss_t ss_s;
	logic out_v_q;
	logic [OW-1:0] out_q;

	logic [NW:0] dd;
	logic [2*MW-1:0] lsq, emul;
	logic [MW:0] lt;
	logic [CW-1:0] c0;
	logic [PBW-1:0] p0;
	logic signed [LW-1:0] lval;
	logic signed [YW-1:0] yv;
	logic signed [QW-1:0] qv;
	logic signed [CSW-1:0] cs, rs, fs, num, den;
	logic [TRW:0] tdd;
	logic [SPW-1:0] sprod;
	logic [OW-1:0] sm;
	logic [2*OW-1:0] rprod;

	// Cosine divide: one quotient bit per stage.
	always_comb begin
		for (int i = 0; i < CW; i++) begin
			div_nx[i] = div_s[i];
			dd = (NW + 1)'(info.len) << (CW - 1 - i);
			if ({1'b0, div_s[i].rem} >= dd) begin
				div_nx[i].rem = div_s[i].rem - dd[NW-1:0];
				div_nx[i].quo[CW-1-i] = 1'b1;
			end
		end
	end

	// Log2 entry normalization and repeated squaring.
	always_comb begin
		c0 = div_s[CW].quo;
		p0 = '0;
		for (int j = 0; j < CW; j++) begin
			if (c0[j]) begin
				p0 = PBW'(j);
			end
		end
		lg_nx[0].kill = div_s[CW].kill;
		lg_nx[0].czero = (c0 == '0);
		lg_nx[0].c = c0;
		lg_nx[0].p = p0;
		lg_nx[0].m = MW'(c0) << (PBW'(MW - 1) - p0);
		lg_nx[0].frac = '0;
		for (int i = 0; i < FRAC_BITS; i++) begin
			lg_nx[i+1] = lg_s[i];
			lsq = (2 * MW)'(lg_s[i].m) * (2 * MW)'(lg_s[i].m);
			lt = lsq[2*MW-1:MW-1];
			lg_nx[i+1].frac = {lg_s[i].frac[FRAC_BITS-2:0], lt[MW]};
			lg_nx[i+1].m = lt[MW] ? lt[MW:1] : lt[MW-1:0];
		end
	end

	// Exponent scaling result split into the exp2 start record, and the exp2 root multiply steps.
	always_comb begin
		lval = {LIW'(lg_s[FRAC_BITS].p) - LIW'(Q_FRAC), lg_s[FRAC_BITS].frac};
		yv = mu_s.prod[PW-1:EXP_FRAC];
		qv = yv[YW-1:FRAC_BITS];
		ex_nx[0].kill = mu_s.kill;
		ex_nx[0].c = mu_s.c;
		ex_nx[0].f = yv[FRAC_BITS-1:0];
		ex_nx[0].sh = SHW'(EXP_SH0) - qv[SHW-1:0];
		ex_nx[0].r = MW'(1) << (MW - 1);
		ex_nx[0].fix = 1'b1;
		ex_nx[0].fix_val = OW'(ONE_Q16);
		if (exponent == '0) begin
			ex_nx[0].fix_val = OW'(ONE_Q16);
		end else if (mu_s.czero) begin
			ex_nx[0].fix_val = '0;
		end else if (!yv[YW-1]) begin
			ex_nx[0].fix_val = OW'(ONE_Q16);
		end else if (qv < Q_MIN) begin
			ex_nx[0].fix_val = '0;
		end else begin
			ex_nx[0].fix = 1'b0;
		end
		for (int i = 0; i < FRAC_BITS; i++) begin
			ex_nx[i+1] = ex_s[i];
			emul = (2 * MW)'(ex_s[i].r) * (2 * MW)'(ROOTS[i]);
			if (ex_s[i].f[FRAC_BITS-1-i]) begin
				ex_nx[i+1].r = emul[2*MW-2:MW-1];
			end
		end
	end

	// Smoothstep classification and fraction divide.
	always_comb begin
		cs = CSW'({1'b0, pw_s.c});
		rs = CSW'(cone_radius);
		fs = CSW'(cone_falloff);
		num = cs - fs;
		den = rs - fs;
		sd_nx[0].kill = pw_s.kill;
		sd_nx[0].power = pw_s.power;
		sd_nx[0].rem = TRW'(num[DENW-1:0]) << (TW - 1);
		sd_nx[0].den = den[DENW-1:0];
		sd_nx[0].t = '0;
		if (rs <= 0) begin
			sd_nx[0].mode = SM_OFF;
		end else if (cs < fs) begin
			sd_nx[0].mode = SM_ZERO;
		end else if (cs > rs) begin
			sd_nx[0].mode = SM_ONE;
		end else if (rs == fs) begin
			sd_nx[0].mode = SM_ZERO;
		end else begin
			sd_nx[0].mode = SM_CALC;
		end
		for (int i = 0; i < TW; i++) begin
			sd_nx[i+1] = sd_s[i];
			tdd = (TRW + 1)'(sd_s[i].den) << (TW - 1 - i);
			if ({1'b0, sd_s[i].rem} >= tdd) begin
				sd_nx[i+1].rem = sd_s[i].rem - tdd[TRW-1:0];
				sd_nx[i+1].t[TW-1-i] = 1'b1;
			end
		end
	end

	always_comb begin
		sprod = SPW'(tt_s.w) * SPW'(tt_s.tt);
		case (ss_s.mode)
			SM_ONE:  sm = OW'(ONE_Q16);
			SM_CALC: sm = ss_s.s;
			default: sm = '0;
		endcase
		rprod = (2 * OW)'(ss_s.power) * (2 * OW)'(sm);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= CW; i++) begin
				div_v_s[i] <= 1'b0;
			end
			for (int i = 0; i <= FRAC_BITS; i++) begin
				lg_v_s[i] <= 1'b0;
				ex_v_s[i] <= 1'b0;
			end
			for (int i = 0; i <= TW; i++) begin
				sd_v_s[i] <= 1'b0;
			end
			mu_v_s <= 1'b0;
			pw_v_s <= 1'b0;
			tt_v_s <= 1'b0;
			ss_v_s <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			div_v_s[0] <= in_v;
			for (int i = 0; i < CW; i++) begin
				div_v_s[i+1] <= div_v_s[i];
			end
			lg_v_s[0] <= div_v_s[CW];
			for (int i = 0; i < FRAC_BITS; i++) begin
				lg_v_s[i+1] <= lg_v_s[i];
				ex_v_s[i+1] <= ex_v_s[i];
			end
			mu_v_s <= lg_v_s[FRAC_BITS];
			ex_v_s[0] <= mu_v_s;
			pw_v_s <= ex_v_s[FRAC_BITS];
			sd_v_s[0] <= pw_v_s;
			for (int i = 0; i < TW; i++) begin
				sd_v_s[i+1] <= sd_v_s[i];
			end
			tt_v_s <= sd_v_s[TW];
			ss_v_s <= tt_v_s;
			out_v_q <= ss_v_s;
		end
	end

	always_ff @(posedge clk) begin
		div_s[0].kill <= in_item.kill;
		div_s[0].rem <= in_item.n;
		div_s[0].quo <= '0;
		for (int i = 0; i < CW; i++) begin
			div_s[i+1] <= div_nx[i];
		end
		for (int i = 0; i <= FRAC_BITS; i++) begin
			lg_s[i] <= lg_nx[i];
			ex_s[i] <= ex_nx[i];
		end
		mu_s.kill <= lg_s[FRAC_BITS].kill;
		mu_s.czero <= lg_s[FRAC_BITS].czero;
		mu_s.c <= lg_s[FRAC_BITS].c;
		mu_s.prod <= PW'(lval) * PW'(signed'({1'b0, exponent}));
		pw_s.kill <= ex_s[FRAC_BITS].kill;
		pw_s.c <= ex_s[FRAC_BITS].c;
		pw_s.power <= ex_s[FRAC_BITS].fix ? ex_s[FRAC_BITS].fix_val
			: OW'(ex_s[FRAC_BITS].r >> ex_s[FRAC_BITS].sh);
		for (int i = 0; i <= TW; i++) begin
			sd_s[i] <= sd_nx[i];
		end
		tt_s.kill <= sd_s[TW].kill;
		tt_s.power <= sd_s[TW].power;
		tt_s.mode <= sd_s[TW].mode;
		tt_s.tt <= TTW'((2 * TW)'(sd_s[TW].t) * (2 * TW)'(sd_s[TW].t));
		tt_s.w <= SWW'(SMOOTH_K) - SWW'({sd_s[TW].t, 1'b0});
		ss_s.kill <= tt_s.kill;
		ss_s.power <= tt_s.power;
		ss_s.mode <= tt_s.mode;
		ss_s.s <= sprod[2*Q_FRAC+OW-1:2*Q_FRAC];
		if (ss_s.kill) begin
			out_q <= '0;
		end else if (ss_s.mode == SM_OFF) begin
			out_q <= ss_s.power;
		end else begin
			out_q <= rprod[Q_FRAC+OW-1:Q_FRAC];
		end
	end

	assign done = out_v_q;
	assign attenuation = out_q;

endmodule
